FILE: src/framed_command_receiver_unit_macros.svh
// Assertion macros shared by the framed command receiver RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef FRAMED_COMMAND_RECEIVER_UNIT_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_UNIT_MACROS_SVH

// A condition that must hold at every rising clock edge outside reset.
`define FCR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define FCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define FCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fcr_pkg.sv
// Package of the framed command receiver: constants, register map and shared types.
// No dependencies; the queue, front, back, top level and testbench import it.
package fcr_pkg;

    localparam int PAYLOAD_BYTES = 12;
    localparam int PAYLOAD_BITS  = 8 * PAYLOAD_BYTES;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_HEADER   = 2'd0;
    localparam logic [1:0] REG_TAIL     = 2'd1;
    localparam logic [1:0] REG_DEADZONE = 2'd2;
    localparam logic [1:0] REG_TIMEOUT  = 2'd3;

    localparam logic [7:0]  RST_HEADER   = 8'hA5;
    localparam logic [7:0]  RST_TAIL     = 8'h5A;
    localparam logic [30:0] RST_DEADZONE = 31'h40A0_0000;
    localparam logic [15:0] RST_TIMEOUT  = 16'd500;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;
    localparam logic [30:0] F32_INF_MAG = 31'h7F80_0000;

    // Input kinds and result events.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic EV_FRAME  = 1'b0;
    localparam logic EV_STOP   = 1'b1;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  tail_byte;
        logic [30:0] deadzone_magnitude;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // One command handed from the parser to the output side.
    typedef struct packed {
        logic                    event_res;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_cmd;

endpackage

FILE: src/fcr_if.sv
// Valid/ready channel interfaces of the framed command receiver.
// No dependencies; used by the front, back and top-level modules.
interface fcr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface fcr_out_if;
    logic        valid;
    logic        ready;
    logic        event_res;
    logic [31:0] forward_speed;
    logic [31:0] side_speed;
    logic [31:0] turn_rate;

    modport source (
        output valid, output event_res, output forward_speed,
        output side_speed, output turn_rate, input ready
    );
    modport sink (
        input valid, input event_res, input forward_speed,
        input side_speed, input turn_rate, output ready
    );
endinterface

FILE: src/fcr_queue.sv
// Short command queue between the frame parser and the output stage.
// Depends on fcr_pkg and the assertion macro header.
`include "framed_command_receiver_unit_macros.svh"

module fcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcr_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output fcr_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import fcr_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `FCR_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `FCR_ASSERT_ALWAYS(a_count_in_range, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

FILE: src/fcr_front.sv
// Front end: accepts bytes and ticks, parses frames and runs the link timer.
// Depends on fcr_pkg, fcr_if and the assertion macro header.
`include "framed_command_receiver_unit_macros.svh"

module fcr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcr_in_if.sink        i_in,
    input  fcr_pkg::t_cfg i_cfg,
    output logic          o_cmd_valid,
    output fcr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_ready
);
    import fcr_pkg::*;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CHECK   = 2'd2;
    localparam logic [1:0] PH_TAIL    = 2'd3;

    logic [1:0]              r_phase;
    logic [CNT_W-1:0]        r_count;
    logic [7:0]              r_sum;
    logic [7:0]              r_store [PAYLOAD_BYTES];
    logic [15:0]             r_elapsed;
    logic                    r_stopped;
    logic [1:0]              n_phase;
    logic [CNT_W-1:0]        n_count;
    logic [7:0]              n_sum;
    logic [15:0]             n_elapsed;
    logic                    n_stopped;
    logic                    w_accept;
    logic                    w_store_we;
    logic [15:0]             w_tick_inc;
    logic [PAYLOAD_BITS-1:0] w_frame_bits;

    // Every item needs a free queue slot, so a result never has to wait.
    assign i_in.ready = i_cmd_ready;
    assign w_accept   = i_in.valid & i_cmd_ready;
    assign w_tick_inc = (r_elapsed != TICK_MAX) ? r_elapsed + 16'd1 : r_elapsed;

    always_comb begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            w_frame_bits[8*i +: 8] = r_store[i];
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_count         = r_count;
        n_sum           = r_sum;
        n_elapsed       = r_elapsed;
        n_stopped       = r_stopped;
        w_store_we      = 1'b0;
        o_cmd_valid     = 1'b0;
        o_cmd.event_res = EV_FRAME;
        o_cmd.payload   = w_frame_bits;
        if (w_accept) begin
            if (i_in.kind == KIND_TICK) begin
                n_elapsed = w_tick_inc;
                if ((w_tick_inc > i_cfg.timeout_ticks) && !r_stopped) begin
                    n_stopped       = 1'b1;
                    o_cmd_valid     = 1'b1;
                    o_cmd.event_res = EV_STOP;
                    o_cmd.payload   = '0;
                end
            end else begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_in.rx_byte == i_cfg.header_byte) begin
                            n_phase = PH_PAYLOAD;
                            n_sum   = '0;
                            n_count = '0;
                        end
                    end
                    PH_PAYLOAD: begin
                        w_store_we = 1'b1;
                        n_sum      = r_sum + i_in.rx_byte;
                        n_count    = r_count + 1'b1;
                        if (n_count == CNT_W'(PAYLOAD_BYTES)) begin
                            n_phase = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        n_phase = (i_in.rx_byte == r_sum) ? PH_TAIL : PH_HUNT;
                    end
                    default: begin
                        n_phase = PH_HUNT;
                        if (i_in.rx_byte == i_cfg.tail_byte) begin
                            n_elapsed   = '0;
                            n_stopped   = 1'b0;
                            o_cmd_valid = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_count   <= '0;
            r_sum     <= '0;
            r_elapsed <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_elapsed <= n_elapsed;
            r_stopped <= n_stopped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[r_count] <= i_in.rx_byte;
        end
    end

    `FCR_ASSERT_NEXT(a_stop_sets_flag, i_clk, i_rst_n, o_cmd_valid && (o_cmd.event_res == EV_STOP), r_stopped, "stop sent without latching stop flag")
    `FCR_ASSERT_NEXT(a_frame_clears_timer, i_clk, i_rst_n, o_cmd_valid && (o_cmd.event_res == EV_FRAME), (r_elapsed == '0) && !r_stopped, "good frame did not restart timer")

endmodule

FILE: src/fcr_back.sv
// Back end: applies the dead zone to decoded values and holds the result register.
// Depends on fcr_pkg, fcr_if and the assertion macro header.
`include "framed_command_receiver_unit_macros.svh"

module fcr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fcr_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  fcr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    fcr_out_if.source     o_out
);
    import fcr_pkg::*;

    logic        r_valid;
    logic        r_event;
    logic [31:0] r_forward;
    logic [31:0] r_side;
    logic [31:0] r_turn;

    // NaN passes; any other value with magnitude below the threshold becomes +0.0.
    function automatic logic [31:0] dead_zone(input logic [31:0] bits,
                                              input logic [30:0] limit);
        logic [30:0] mag;
        mag = bits[30:0];
        if (mag > F32_INF_MAG) begin
            return bits;
        end else if (mag < limit) begin
            return '0;
        end
        return bits;
    endfunction

    assign o_cmd_pop = i_cmd_valid && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_event   <= i_cmd.event_res;
            r_forward <= dead_zone(i_cmd.payload[31:0], i_cfg.deadzone_magnitude);
            r_side    <= dead_zone(i_cmd.payload[63:32], i_cfg.deadzone_magnitude);
            r_turn    <= dead_zone(i_cmd.payload[95:64], i_cfg.deadzone_magnitude);
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.event_res     = r_event;
    assign o_out.forward_speed = r_forward;
    assign o_out.side_speed    = r_side;
    assign o_out.turn_rate     = r_turn;

    `FCR_ASSERT_NEXT(a_pop_fills_output, i_clk, i_rst_n, o_cmd_pop, r_valid, "popped command not presented")

endmodule

FILE: src/framed_command_receiver_unit.sv
// Top level of the framed command receiver: register file and block wiring.
// Depends on fcr_pkg, fcr_if, fcr_front, fcr_queue and fcr_back.
//
// This block takes one transaction per clock cycle on its input channel, each
// either a received serial byte or a one millisecond tick, and keeps taking
// them at that rate while the queue has room for results. A frame is a header
// byte, twelve payload bytes, a checksum byte equal to the payload sum modulo
// 256 and a tail byte. A bad checksum or a wrong tail drops the frame and the
// parser hunts for the next header. A good frame produces one output
// transaction with event_res clear and three little-endian IEEE single
// patterns, each forced to +0.0 when its magnitude lies below the dead-zone
// register (NaN is passed unchanged); it also restarts the tick counter, which
// saturates at 65535. The first tick that takes the counter above the timeout
// register produces one stop transaction (event_res set, values zero); no
// further stop is sent until the next good frame. The parser and timer in the
// front end hand results to a two-entry command queue, and an output register
// in the back end presents them; each result passes through the queue and
// then the output register. The input channel stalls only when both queue
// entries are occupied, which takes three results waiting at once: one held
// in the output register by the receiver and two behind it in the queue.
// Registers sit on the APB port at byte addresses 0x0 (header), 0x4 (tail),
// 0x8 (dead-zone magnitude) and 0xC (timeout), and should be written while no
// transaction is in progress.

module framed_command_receiver_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fcr_in_if.sink                         i_in,
    fcr_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fcr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [fcr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [fcr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import fcr_pkg::*;

    t_cfg       r_cfg;
    logic       w_cfg_write;
    logic [1:0] w_reg_index;
    logic       w_cmd_valid;
    t_cmd       w_cmd;
    logic       w_queue_full;
    logic       w_queue_valid;
    t_cmd       w_queue_data;
    logic       w_pop;

    // The register file never inserts wait states.
    assign pready      = 1'b1;
    assign w_cfg_write = psel & penable & pwrite & pready;
    assign w_reg_index = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_byte        <= RST_HEADER;
            r_cfg.tail_byte          <= RST_TAIL;
            r_cfg.deadzone_magnitude <= RST_DEADZONE;
            r_cfg.timeout_ticks      <= RST_TIMEOUT;
        end else if (w_cfg_write) begin
            case (w_reg_index)
                REG_HEADER:   r_cfg.header_byte        <= pwdata[7:0];
                REG_TAIL:     r_cfg.tail_byte          <= pwdata[7:0];
                REG_DEADZONE: r_cfg.deadzone_magnitude <= pwdata[30:0];
                REG_TIMEOUT:  r_cfg.timeout_ticks      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Reads return the stored value, zero-extended to the bus width.
    always_comb begin
        case (w_reg_index)
            REG_HEADER:   prdata = CFG_DATA_W'(r_cfg.header_byte);
            REG_TAIL:     prdata = CFG_DATA_W'(r_cfg.tail_byte);
            REG_DEADZONE: prdata = CFG_DATA_W'(r_cfg.deadzone_magnitude);
            REG_TIMEOUT:  prdata = CFG_DATA_W'(r_cfg.timeout_ticks);
            default:      prdata = '0;
        endcase
    end

    // The parser pushes at most one command per accepted transaction.
    fcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (!w_queue_full)
    );

    fcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_data  (w_cmd),
        .o_full  (w_queue_full),
        .o_valid (w_queue_valid),
        .o_data  (w_queue_data),
        .i_pop   (w_pop)
    );

    // The output stage applies the dead zone as it loads its register.
    fcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_queue_valid),
        .i_cmd       (w_queue_data),
        .o_cmd_pop   (w_pop),
        .o_out       (o_out)
    );

endmodule

FILE: tb/tb_framed_command_receiver_unit.sv
// Self-checking testbench of the framed command receiver: frames, ticks, dead zone and timeout.
// Depends on fcr_pkg, the fcr_in_if / fcr_out_if interfaces and framed_command_receiver_unit.
`timescale 1ns / 100ps

module tb_framed_command_receiver_unit;
    import fcr_pkg::*;

    // Run limits. Results pass through the command queue and output register, so a
    // short guard after the expected-result queue drains covers anything still in flight.
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int          DRAIN_GUARD  = 8;
    localparam int          PHASE_ITEMS  = 220;
    localparam int          RANDOM_PHASES = 6;
    localparam int          LONG_TICKS   = 40;

    typedef enum logic [1:0] {PH_HUNT, PH_PAYLOAD, PH_SUM, PH_TAIL} t_parse_phase;
    typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_TAIL, FRAME_CUT} t_frame_fault;
    typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN, RX_BLOCKED} t_rx_mode;

    typedef struct packed {
        logic        event_res;
        logic [31:0] forward_speed;
        logic [31:0] side_speed;
        logic [31:0] turn_rate;
    } t_cmd_result;

    logic i_clk;
    logic i_rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    fcr_in_if  in_if ();
    fcr_out_if out_if ();

    framed_command_receiver_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Free-running clock, 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the register file and of the deframer state. Every
    // accepted input transaction advances it and may queue one expected result.
    logic [7:0]   cfg_header;
    logic [7:0]   cfg_tail;
    logic [30:0]  cfg_deadzone;
    logic [15:0]  cfg_timeout;
    t_parse_phase parse_phase;
    logic [3:0]   parse_count;
    logic [7:0]   parse_sum;
    logic [7:0]   payload_bytes [PAYLOAD_BYTES];
    logic [15:0]  tick_count;
    logic         stop_sent;

    t_cmd_result  pending_commands [$];
    t_cmd_result  head_cmd;
    int           error_count;
    int unsigned  cycle_count;
    int           items_sent;
    int           burst_left;

    t_rx_mode     rx_mode;
    int           rx_run;
    int unsigned  rx_beat;

    function automatic void note_error(string what, logic [31:0] want, logic [31:0] got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch in %s: expected %h, actual %h", what, want, got);
    endfunction

    function automatic void reset_model();
        cfg_header   = RST_HEADER;
        cfg_tail     = RST_TAIL;
        cfg_deadzone = RST_DEADZONE;
        cfg_timeout  = RST_TIMEOUT;
        parse_phase  = PH_HUNT;
        parse_count  = '0;
        parse_sum    = '0;
        tick_count   = '0;
        stop_sent    = 1'b0;
        foreach (payload_bytes[i]) payload_bytes[i] = '0;
    endfunction

    function automatic void apply_cfg(logic [1:0] idx, logic [31:0] value);
        case (idx)
            REG_HEADER:   cfg_header   = value[7:0];
            REG_TAIL:     cfg_tail     = value[7:0];
            REG_DEADZONE: cfg_deadzone = value[30:0];
            default:      cfg_timeout  = value[15:0];
        endcase
    endfunction

    function automatic logic [31:0] cfg_value(logic [1:0] idx);
        case (idx)
            REG_HEADER:   return {24'd0, cfg_header};
            REG_TAIL:     return {24'd0, cfg_tail};
            REG_DEADZONE: return {1'b0, cfg_deadzone};
            default:      return {16'd0, cfg_timeout};
        endcase
    endfunction

    // Payload words are little endian: the lowest stored byte is bits 7:0.
    function automatic logic [31:0] payload_word(int base);
        return {payload_bytes[base + 3], payload_bytes[base + 2],
                payload_bytes[base + 1], payload_bytes[base]};
    endfunction

    // Magnitudes below the threshold collapse to +0.0, but NaN always survives.
    function automatic logic [31:0] apply_deadzone(logic [31:0] bits);
        if (bits[30:0] > F32_INF_MAG) return bits;
        if (bits[30:0] < cfg_deadzone) return '0;
        return bits;
    endfunction

    function automatic void deframe_step(logic kind, logic [7:0] rx);
        t_cmd_result res;
        res = '0;
        if (kind == KIND_TICK) begin
            if (tick_count != TICK_MAX) tick_count++;
            if (tick_count > cfg_timeout && !stop_sent) begin
                stop_sent = 1'b1;
                res.event_res = EV_STOP;
                pending_commands.push_back(res);
            end
            return;
        end
        case (parse_phase)
            PH_HUNT: begin
                if (rx == cfg_header) begin
                    parse_phase = PH_PAYLOAD;
                    parse_sum   = '0;
                    parse_count = '0;
                end
            end
            PH_PAYLOAD: begin
                payload_bytes[parse_count] = rx;
                parse_sum   = parse_sum + rx;
                parse_count = parse_count + 4'd1;
                if (parse_count >= PAYLOAD_BYTES) parse_phase = PH_SUM;
            end
            PH_SUM: begin
                parse_phase = (rx == parse_sum) ? PH_TAIL : PH_HUNT;
            end
            default: begin
                parse_phase = PH_HUNT;
                if (rx == cfg_tail) begin
                    tick_count        = '0;
                    stop_sent         = 1'b0;
                    res.event_res     = EV_FRAME;
                    res.forward_speed = apply_deadzone(payload_word(0));
                    res.side_speed    = apply_deadzone(payload_word(4));
                    res.turn_rate     = apply_deadzone(payload_word(8));
                    pending_commands.push_back(res);
                end
            end
        endcase
    endfunction

    // Every accepted output transaction is matched against the oldest expected result.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_commands.size() == 0) begin
                note_error("unexpected result, event", '0, 32'(out_if.event_res));
            end else begin
                head_cmd = pending_commands.pop_front();
                if (out_if.event_res !== head_cmd.event_res)
                    note_error("event_res", 32'(head_cmd.event_res), 32'(out_if.event_res));
                if (out_if.forward_speed !== head_cmd.forward_speed)
                    note_error("forward_speed", head_cmd.forward_speed, out_if.forward_speed);
                if (out_if.side_speed !== head_cmd.side_speed)
                    note_error("side_speed", head_cmd.side_speed, out_if.side_speed);
                if (out_if.turn_rate !== head_cmd.turn_rate)
                    note_error("turn_rate", head_cmd.turn_rate, out_if.turn_rate);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver switches among stretches of steady acceptance, random
    // stalls, a fixed duty pattern and long hold-offs that let the queue fill.
    always @(negedge i_clk) begin
        if (rx_run <= 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_run  = (rx_mode == RX_BLOCKED) ? $urandom_range(5, 40) : $urandom_range(20, 200);
        end
        rx_run--;
        rx_beat++;
        case (rx_mode)
            RX_STEADY:  out_if.ready <= 1'b1;
            RX_RANDOM:  out_if.ready <= ($urandom_range(0, 2) != 0);
            RX_PATTERN: out_if.ready <= ((rx_beat % 7) < 4);
            default:    out_if.ready <= 1'b0;
        endcase
    end

    // All stimulus tasks start and end at a falling edge, so each drive
    // happens once per time step and the DUT samples settled inputs.
    task automatic send_item(input logic kind, input logic [7:0] rx);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_if.valid   <= 1'b1;
        in_if.kind    <= kind;
        in_if.rx_byte <= rx;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        deframe_step(kind, rx);
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 8'($urandom));
    endtask

    // Sends header, twelve payload bytes, checksum and tail, or a damaged
    // variant. tick_slot places one tick before that payload byte; a
    // negative value scatters ticks at random instead.
    task automatic send_frame(input logic [31:0] w0, input logic [31:0] w1,
                              input logic [31:0] w2, input t_frame_fault fault,
                              input int tick_slot);
        logic [95:0] words;
        logic [7:0]  sum;
        logic [7:0]  pb;
        int          cut;
        words = {w2, w1, w0};
        sum   = '0;
        cut   = (fault == FRAME_CUT) ? $urandom_range(1, PAYLOAD_BYTES - 1) : PAYLOAD_BYTES;
        send_item(KIND_BYTE, cfg_header);
        for (int i = 0; i < cut; i++) begin
            if (i == tick_slot || (tick_slot < 0 && $urandom_range(0, 11) == 0))
                send_tick();
            pb  = words[8*i +: 8];
            sum = sum + pb;
            send_item(KIND_BYTE, pb);
        end
        if (fault == FRAME_CUT) return;
        send_item(KIND_BYTE, (fault == FRAME_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum);
        send_item(KIND_BYTE,
                  (fault == FRAME_BAD_TAIL) ? cfg_tail ^ 8'($urandom_range(1, 255)) : cfg_tail);
    endtask

    // Lowers valid and holds off until every expected result has arrived.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_commands.size() != 0) @(negedge i_clk);
        repeat (DRAIN_GUARD) @(negedge i_clk);
    endtask

    task automatic cfg_read_check(input logic [1:0] idx);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== cfg_value(idx)) note_error("register readback", cfg_value(idx), prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // Writes one register, then reads it back.
    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        apply_cfg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        cfg_read_check(idx);
    endtask

    task automatic set_config(input logic [7:0] header, input logic [7:0] tail,
                              input logic [30:0] deadzone, input logic [15:0] timeout);
        cfg_write(REG_HEADER, {24'd0, header});
        cfg_write(REG_TAIL, {24'd0, tail});
        cfg_write(REG_DEADZONE, {1'b0, deadzone});
        cfg_write(REG_TIMEOUT, {16'd0, timeout});
    endtask

    // Float patterns that lean on the interesting corners: NaN, infinity,
    // signed zero, values right at the threshold and ordinary magnitudes.
    function automatic logic [31:0] random_float();
        logic sign;
        sign = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return {sign, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
            2: return {sign, F32_INF_MAG};
            3: return {sign, 31'd0};
            4: return {sign, cfg_deadzone};
            5: return {sign, cfg_deadzone + 31'($urandom_range(0, 2)) - 31'd1};
            default: return {sign, 8'($urandom_range(120, 135)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [30:0] random_deadzone();
        case ($urandom_range(0, 3))
            0: return RST_DEADZONE;
            1: return 31'($urandom);
            2: return {8'($urandom_range(124, 131)), 23'($urandom)};
            default: return 31'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic test_register_reset();
        cfg_read_check(REG_HEADER);
        cfg_read_check(REG_TAIL);
        cfg_read_check(REG_DEADZONE);
        cfg_read_check(REG_TIMEOUT);
    endtask

    // One good frame under the reset settings: a NaN, a negative value in
    // the dead zone and a value exactly at the threshold, with a byte before
    // the header while idle and a tick in the middle of the payload.
    task automatic test_frame_special_values();
        send_item(KIND_BYTE, 8'h00);
        send_frame(32'h7FC0_0001, 32'hC09F_FFFF, 32'h40A0_0000, FRAME_GOOD, 5);
        wait_drained();
    endtask

    // A zero timeout stops on the first tick, and only once.
    task automatic test_timeout_stop();
        cfg_write(REG_TIMEOUT, 32'd0);
        send_tick();
        send_tick();
        wait_drained();
    endtask

    // Phases of mostly well-formed frames with random content, mixed with
    // damaged frames, tick runs and noise, each phase on its own settings.
    task automatic test_random_traffic();
        int start;
        int pick;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_config(8'h00, 8'hFF, 31'd0, 16'd0);
                1: set_config(8'hFF, 8'h00, 31'h7FFF_FFFF, 16'hFFFF);
                2: set_config(RST_HEADER, RST_TAIL, RST_DEADZONE, 16'd20);
                default: set_config(8'($urandom), 8'($urandom), random_deadzone(),
                                    16'($urandom_range(0, 40)));
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_frame(random_float(), random_float(), random_float(), FRAME_GOOD, -1);
                else if (pick < 78)
                    send_frame(random_float(), random_float(), random_float(), FRAME_BAD_SUM, -1);
                else if (pick < 84)
                    send_frame(random_float(), random_float(), random_float(), FRAME_BAD_TAIL, -1);
                else if (pick < 88)
                    send_frame(random_float(), random_float(), random_float(), FRAME_CUT, -1);
                else if (pick < 96)
                    repeat ($urandom_range(1, 8)) send_tick();
                else
                    repeat ($urandom_range(1, 4)) send_item(KIND_BYTE, 8'($urandom));
                // In phase 3, steps ending at items 110 to 129 wait for the output side.
                if (ph == 3 && items_sent - start >= PHASE_ITEMS / 2 &&
                    items_sent - start < PHASE_ITEMS / 2 + 20)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    // With the largest timeout a long run of ticks never stops; lowering the
    // timeout below the count already reached lets the next tick trigger the stop.
    task automatic test_large_timeout();
        set_config(RST_HEADER, RST_TAIL, RST_DEADZONE, 16'hFFFF);
        send_frame(random_float(), random_float(), random_float(), FRAME_GOOD, PAYLOAD_BYTES);
        repeat (LONG_TICKS) send_tick();
        wait_drained();
        cfg_write(REG_TIMEOUT, 32'(LONG_TICKS / 2));
        send_tick();
        send_tick();
        wait_drained();
    endtask

    initial begin
        error_count   = 0;
        cycle_count   = 0;
        items_sent    = 0;
        burst_left    = 0;
        rx_run        = 0;
        rx_beat       = 0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.kind    = KIND_BYTE;
        in_if.rx_byte = 8'h00;
        out_if.ready  = 1'b1;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        reset_model();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_register_reset();
        test_frame_special_values();
        test_timeout_stop();
        test_random_traffic();
        test_large_timeout();
        wait_drained();

        if (pending_commands.size() != 0)
            note_error("results still outstanding", '0, 32'(pending_commands.size()));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
